/* design/rhp_pkg.sv */
package rhp_pkg;

    // Fixed header is 3 words of 4 bytes
    localparam int unsigned HDR_BYTES    = 3 * 4;
    localparam int unsigned POS_W        = 7;
    localparam int unsigned CSRC_W       = 4;
    localparam int unsigned SEQ_W        = 16;
    localparam int unsigned DROP_W       = 15;
    localparam int unsigned MAX_CSRC_DEF = 15;
    localparam logic [SEQ_W-1:0] SEQ_HALF = 16'd32767;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CSRC   = 2'd1,
        KIND_SHORT  = 2'd2,
        KIND_TRUNC  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ORD_IN_ORDER  = 3'd0,
        ORD_GAP       = 3'd1,
        ORD_BACKWARDS = 3'd2,
        ORD_REPEAT    = 3'd3,
        ORD_FIRST     = 3'd4
    } order_t;

    typedef struct packed {
        kind_t              kind;
        logic [1:0]         version;
        logic               padding;
        logic               extension;
        logic [3:0]         csrc_count;
        logic               marker;
        logic [6:0]         media_type;
        logic [SEQ_W-1:0]   sequence_res;
        logic [31:0]        timestamp;
        logic [31:0]        word;
        order_t             order_status;
        logic [DROP_W-1:0]  dropped;
    } result_t;

    // Header fields of a result; everything else left zero
    function automatic result_t header_fields(
        input logic [7:0]       first_octet,
        input logic [7:0]       second_octet,
        input logic [SEQ_W-1:0] seq,
        input logic [31:0]      ts
    );
        result_t r;
        r              = '0;
        r.version      = first_octet[7:6];
        r.padding      = first_octet[5];
        r.extension    = first_octet[4];
        r.csrc_count   = first_octet[3:0];
        r.marker       = second_octet[7];
        r.media_type   = second_octet[6:0];
        r.sequence_res = seq;
        r.timestamp    = ts;
        return r;
    endfunction

endpackage

/* design/rhp_core.sv */
module rhp_core #(
    parameter int unsigned MAX_CSRC = rhp_pkg::MAX_CSRC_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat,
    input  logic [7:0]       byte_value,
    input  logic             packet_end,
    output logic             res_valid,
    output rhp_pkg::result_t res
);

    localparam logic [rhp_pkg::CSRC_W-1:0] CSRC_MAX = rhp_pkg::CSRC_W'(MAX_CSRC);
    localparam rhp_pkg::pos_t POS_HDR  = rhp_pkg::POS_W'(rhp_pkg::HDR_BYTES);
    localparam rhp_pkg::pos_t POS_LAST = rhp_pkg::POS_W'(rhp_pkg::HDR_BYTES - 1);

    rhp_pkg::pos_t                 pos_reg, pos_next;
    logic                          in_payload_reg, in_payload_next;
    logic [rhp_pkg::CSRC_W-1:0]    csrc_reg, csrc_next;
    logic [rhp_pkg::SEQ_W-1:0]     prev_seq_reg, prev_seq_next;
    logic                          prev_valid_reg, prev_valid_next;
    logic [7:0]                    first_reg, first_next;
    logic [7:0]                    second_reg, second_next;
    logic [rhp_pkg::SEQ_W-1:0]     seq_reg, seq_next;
    logic [31:0]                   ts_reg, ts_next;
    logic [31:0]                   ws_reg, ws_next;

    logic [31:0]                   ws_shift;
    logic [rhp_pkg::CSRC_W-1:0]    cc_clamped;
    logic [rhp_pkg::CSRC_W-1:0]    csrc_dec;
    logic [rhp_pkg::SEQ_W-1:0]     delta;
    rhp_pkg::order_t               order;
    logic [rhp_pkg::DROP_W-1:0]    drop_cnt;
    rhp_pkg::result_t              hdr;

    assign ws_shift   = {ws_reg[23:0], byte_value};
    assign cc_clamped = (first_reg[3:0] > CSRC_MAX) ? CSRC_MAX : first_reg[3:0];
    assign csrc_dec   = csrc_reg - 1'b1;
    assign hdr        = rhp_pkg::header_fields(first_reg, second_reg, seq_reg, ts_reg);

    // Sequence order check against the previous header
    assign delta = seq_reg - prev_seq_reg;

    always_comb
    begin
        drop_cnt = '0;
        if (!prev_valid_reg)
        begin
            order = rhp_pkg::ORD_FIRST;
        end
        else if (delta > rhp_pkg::SEQ_HALF)
        begin
            order = rhp_pkg::ORD_BACKWARDS;
        end
        else if (delta == '0)
        begin
            order = rhp_pkg::ORD_REPEAT;
        end
        else if (delta == rhp_pkg::SEQ_W'(1))
        begin
            order = rhp_pkg::ORD_IN_ORDER;
        end
        else
        begin
            order    = rhp_pkg::ORD_GAP;
            drop_cnt = rhp_pkg::DROP_W'(delta - 1'b1);
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        in_payload_next = in_payload_reg;
        csrc_next       = csrc_reg;
        prev_seq_next   = prev_seq_reg;
        prev_valid_next = prev_valid_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        seq_next        = seq_reg;
        ts_next         = ts_reg;
        ws_next         = ws_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (beat)
        begin
            if (in_payload_reg)
            begin
                if (packet_end)
                begin
                    pos_next        = '0;
                    in_payload_next = 1'b0;
                    csrc_next       = '0;
                end
            end
            else if (pos_reg < POS_HDR)
            begin
                // fixed header bytes
                if (pos_reg == '0)
                begin
                    first_next = byte_value;
                end
                else if (pos_reg == rhp_pkg::POS_W'(1))
                begin
                    second_next = byte_value;
                end
                else if (pos_reg < rhp_pkg::POS_W'(4))
                begin
                    seq_next = {seq_reg[7:0], byte_value};
                end
                else if (pos_reg < rhp_pkg::POS_W'(8))
                begin
                    ts_next = {ts_reg[23:0], byte_value};
                end
                else
                begin
                    ws_next = ws_shift;
                end

                if (pos_reg != POS_LAST)
                begin
                    if (packet_end)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = rhp_pkg::KIND_SHORT;
                        pos_next       = '0;
                        csrc_next      = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else
                begin
                    res_valid        = 1'b1;
                    res              = hdr;
                    res.word         = ws_shift;
                    res.order_status = order;
                    res.dropped      = drop_cnt;
                    prev_seq_next    = seq_reg;
                    prev_valid_next  = 1'b1;
                    if (cc_clamped == '0)
                    begin
                        res.kind  = rhp_pkg::KIND_HEADER;
                        pos_next  = '0;
                        in_payload_next = !packet_end;
                    end
                    else if (packet_end)
                    begin
                        res.kind  = rhp_pkg::KIND_TRUNC;
                        pos_next  = '0;
                        csrc_next = '0;
                    end
                    else
                    begin
                        res.kind  = rhp_pkg::KIND_HEADER;
                        csrc_next = cc_clamped;
                        pos_next  = POS_HDR;
                    end
                end
            end
            else
            begin
                // CSRC list; words align on 4 since the header is 12 bytes
                ws_next = ws_shift;
                if (pos_reg[1:0] == 2'b11)
                begin
                    res_valid = 1'b1;
                    csrc_next = csrc_dec;
                    if (csrc_dec == '0)
                    begin
                        res.kind        = rhp_pkg::KIND_CSRC;
                        res.word        = ws_shift;
                        pos_next        = '0;
                        in_payload_next = !packet_end;
                    end
                    else if (packet_end)
                    begin
                        res       = hdr;
                        res.kind  = rhp_pkg::KIND_TRUNC;
                        res.word  = ws_shift;
                        pos_next  = '0;
                        csrc_next = '0;
                    end
                    else
                    begin
                        res.kind = rhp_pkg::KIND_CSRC;
                        res.word = ws_shift;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else if (packet_end)
                begin
                    res_valid = 1'b1;
                    res       = hdr;
                    res.kind  = rhp_pkg::KIND_TRUNC;
                    pos_next  = '0;
                    csrc_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            in_payload_reg <= 1'b0;
            csrc_reg       <= '0;
            prev_seq_reg   <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            in_payload_reg <= in_payload_next;
            csrc_reg       <= csrc_next;
            prev_seq_reg   <= prev_seq_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    // header shift registers are fully rewritten before use
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        seq_reg    <= seq_next;
        ts_reg     <= ts_next;
        ws_reg     <= ws_next;
    end

    a_payload_parked: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (pos_reg == '0 && csrc_reg == '0))
        else $error("payload skip with live position or CSRC count");

    a_csrc_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (csrc_reg != '0) |-> (pos_reg >= POS_HDR))
        else $error("CSRC count pending outside the CSRC list");

    a_drop_gap_only: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.dropped != '0) |-> (res.order_status == rhp_pkg::ORD_GAP))
        else $error("dropped count without a gap");

endmodule

/* design/rtp_header_parser.sv */
// RTP fixed-header parser.
// Input channel: one packet byte per beat (byte_value, packet_end on the
// last byte), handshake in_valid / in_stall. Output channel: one result per
// beat (kind plus header fields, word, order_status, dropped), handshake
// out_valid / out_stall.
// A byte is taken on every cycle with in_valid high and in_stall low, so a
// line-rate stream runs at 1 byte per cycle. Byte 12 of a header yields the
// header result with its sequence check, or a truncated one if packet_end
// comes with CSRCs due; each completed CSRC word yields a CSRC result;
// packet_end before byte 12 yields a short-packet result and packet_end
// inside the CSRC list a truncated result. Payload bytes give none.
// The output register is backed by a one-entry skid register; in_stall is
// high only while that skid entry is full, so a stalled receiver costs at
// most one extra result of buffering before the input stalls. in_stall is a
// register output and does not depend combinationally on out_stall.
// Reset (rst_n, async, active low) returns the parser to the start of a
// packet, clears the previous-sequence history and empties both registers.
module rtp_header_parser #(
    parameter int unsigned MAX_CSRC = rhp_pkg::MAX_CSRC_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        packet_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  version,
    output logic        padding,
    output logic        extension,
    output logic [3:0]  csrc_count,
    output logic        marker,
    output logic [6:0]  media_type,
    output logic [15:0] sequence_res,
    output logic [31:0] timestamp,
    output logic [31:0] word,
    output logic [2:0]  order_status,
    output logic [14:0] dropped
);

    logic             beat;
    logic             res_valid;
    rhp_pkg::result_t res;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    rhp_pkg::result_t out_reg, out_next;
    rhp_pkg::result_t skid_reg, skid_next;
    logic             out_take;

    assign beat     = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    rhp_core #(
        .MAX_CSRC (MAX_CSRC)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .byte_value (byte_value),
        .packet_end (packet_end),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign version      = out_reg.version;
    assign padding      = out_reg.padding;
    assign extension    = out_reg.extension;
    assign csrc_count   = out_reg.csrc_count;
    assign marker       = out_reg.marker;
    assign media_type   = out_reg.media_type;
    assign sequence_res = out_reg.sequence_res;
    assign timestamp    = out_reg.timestamp;
    assign word         = out_reg.word;
    assign order_status = out_reg.order_status;
    assign dropped      = out_reg.dropped;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_csrc_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == rhp_pkg::KIND_CSRC)
            |-> (out_reg.order_status == rhp_pkg::ORD_IN_ORDER && out_reg.version == '0
                 && out_reg.sequence_res == '0))
        else $error("CSRC beat carries header fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result beat changed");

endmodule

/* tb/sv/rtp_header_parser_checker.sv */
module rtp_header_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        packet_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [1:0]  version,
    input  logic        padding,
    input  logic        extension,
    input  logic [3:0]  csrc_count,
    input  logic        marker,
    input  logic [6:0]  media_type,
    input  logic [15:0] sequence_res,
    input  logic [31:0] timestamp,
    input  logic [31:0] word,
    input  logic [2:0]  order_status,
    input  logic [14:0] dropped,
    output int          errors,
    output int          pending,
    output int          compared
);

    localparam int unsigned CSRC_LIMIT = rhp_pkg::MAX_CSRC_DEF;

    // parser state
    rhp_pkg::pos_t pos;
    logic          in_pay;
    logic [7:0]    oct0;
    logic [7:0]    oct1;
    logic [15:0]   seq_reg;
    logic [31:0]   ts_reg;
    logic [31:0]   word_sh;
    logic [3:0]    csrc_left;
    logic [15:0]   prev_seq;
    logic          prev_ok;

    rhp_pkg::result_t expected_results[$];

    function automatic rhp_pkg::result_t header_of();
        rhp_pkg::result_t r;
        r              = '0;
        r.version      = oct0[7:6];
        r.padding      = oct0[5];
        r.extension    = oct0[4];
        r.csrc_count   = oct0[3:0];
        r.marker       = oct1[7];
        r.media_type   = oct1[6:0];
        r.sequence_res = seq_reg;
        r.timestamp    = ts_reg;
        return r;
    endfunction

    task automatic restart_parse();
        pos       = '0;
        in_pay    = 1'b0;
        csrc_left = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        rhp_pkg::result_t r;
        logic             emit;
        logic [3:0]       n;
        logic [15:0]      delta;
        rhp_pkg::pos_t    off;
        r    = '0;
        emit = 1'b0;
        if (in_pay)
        begin
            if (last)
                restart_parse();
        end
        else if (pos < rhp_pkg::HDR_BYTES)
        begin
            if (pos == 0)
                oct0 = b;
            else if (pos == 1)
                oct1 = b;
            else if (pos < 4)
                seq_reg = {seq_reg[7:0], b};
            else if (pos < 8)
                ts_reg = {ts_reg[23:0], b};
            else
                word_sh = {word_sh[23:0], b};

            if (pos < rhp_pkg::HDR_BYTES - 1)
            begin
                if (last)
                begin
                    r.kind = rhp_pkg::KIND_SHORT;
                    emit   = 1'b1;
                    restart_parse();
                end
                else
                    pos = pos + 1'b1;
            end
            else
            begin
                n = (oct0[3:0] > CSRC_LIMIT) ? 4'(CSRC_LIMIT) : oct0[3:0];
                r      = header_of();
                r.word = word_sh;
                emit   = 1'b1;
                // sequence check against the last header seen
                delta = seq_reg - prev_seq;
                if (!prev_ok)
                    r.order_status = rhp_pkg::ORD_FIRST;
                else if (delta > rhp_pkg::SEQ_HALF)
                    r.order_status = rhp_pkg::ORD_BACKWARDS;
                else if (delta == 16'd0)
                    r.order_status = rhp_pkg::ORD_REPEAT;
                else if (delta == 16'd1)
                    r.order_status = rhp_pkg::ORD_IN_ORDER;
                else
                begin
                    r.order_status = rhp_pkg::ORD_GAP;
                    r.dropped      = 15'(delta - 16'd1);
                end
                prev_seq = seq_reg;
                prev_ok  = 1'b1;

                if (n == 4'd0)
                begin
                    r.kind = rhp_pkg::KIND_HEADER;
                    if (last)
                        restart_parse();
                    else
                    begin
                        pos    = '0;
                        in_pay = 1'b1;
                    end
                end
                else if (last)
                begin
                    r.kind = rhp_pkg::KIND_TRUNC;
                    restart_parse();
                end
                else
                begin
                    r.kind    = rhp_pkg::KIND_HEADER;
                    csrc_left = n;
                    pos       = rhp_pkg::pos_t'(rhp_pkg::HDR_BYTES);
                end
            end
        end
        else
        begin
            // inside the CSRC list
            word_sh = {word_sh[23:0], b};
            off     = pos - rhp_pkg::pos_t'(rhp_pkg::HDR_BYTES);
            if (off[1:0] == 2'd3)
            begin
                csrc_left = csrc_left - 1'b1;
                emit      = 1'b1;
                if (csrc_left == 4'd0)
                begin
                    r.kind = rhp_pkg::KIND_CSRC;
                    r.word = word_sh;
                    if (last)
                        restart_parse();
                    else
                    begin
                        pos    = '0;
                        in_pay = 1'b1;
                    end
                end
                else if (last)
                begin
                    r      = header_of();
                    r.kind = rhp_pkg::KIND_TRUNC;
                    r.word = word_sh;
                    restart_parse();
                end
                else
                begin
                    r.kind = rhp_pkg::KIND_CSRC;
                    r.word = word_sh;
                    pos    = pos + 1'b1;
                end
            end
            else if (last)
            begin
                r      = header_of();
                r.kind = rhp_pkg::KIND_TRUNC;
                emit   = 1'b1;
                restart_parse();
            end
            else
                pos = pos + 1'b1;
        end
        if (emit)
            expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", compared, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rhp_pkg::result_t exp;
        if (!rst_n)
        begin
            restart_parse();
            oct0     = '0;
            oct1     = '0;
            seq_reg  = '0;
            ts_reg   = '0;
            word_sh  = '0;
            prev_seq = '0;
            prev_ok  = 1'b0;
            expected_results.delete();
            errors   = 0;
            compared = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    exp = expected_results.pop_front();
                    check_field("kind", kind, exp.kind);
                    check_field("version", version, exp.version);
                    check_field("padding", padding, exp.padding);
                    check_field("extension", extension, exp.extension);
                    check_field("csrc_count", csrc_count, exp.csrc_count);
                    check_field("marker", marker, exp.marker);
                    check_field("media_type", media_type, exp.media_type);
                    check_field("sequence_res", sequence_res, exp.sequence_res);
                    check_field("timestamp", timestamp, exp.timestamp);
                    check_field("word", word, exp.word);
                    check_field("order_status", order_status, exp.order_status);
                    check_field("dropped", dropped, exp.dropped);
                end
                compared++;
            end
            if (in_valid && !in_stall)
                parse_byte(byte_value, packet_end);
        end
        pending = expected_results.size();
    end

endmodule

/* tb/sv/rtp_header_parser_tb.sv */
module rtp_header_parser_tb;

    localparam int TARGET_BYTES = 680;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 250;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_value;
    logic        packet_end;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [1:0]  version;
    logic        padding;
    logic        extension;
    logic [3:0]  csrc_count;
    logic        marker;
    logic [6:0]  media_type;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] word;
    logic [2:0]  order_status;
    logic [14:0] dropped;

    int errors;
    int pending;
    int compared;

    // sender bookkeeping
    int bytes_sent;
    int packets_sent;
    int packets_cut;
    int burst_left;
    int cycles;

    rtp_header_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .packet_end   (packet_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .version      (version),
        .padding      (padding),
        .extension    (extension),
        .csrc_count   (csrc_count),
        .marker       (marker),
        .media_type   (media_type),
        .sequence_res (sequence_res),
        .timestamp    (timestamp),
        .word         (word),
        .order_status (order_status),
        .dropped      (dropped)
    );

    rtp_header_parser_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .packet_end   (packet_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .version      (version),
        .padding      (padding),
        .extension    (extension),
        .csrc_count   (csrc_count),
        .marker       (marker),
        .media_type   (media_type),
        .sequence_res (sequence_res),
        .timestamp    (timestamp),
        .word         (word),
        .order_status (order_status),
        .dropped      (dropped),
        .errors       (errors),
        .pending      (pending),
        .compared     (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall pattern redrawn for each random phase. Once the sender
    // is well into the random traffic, a long hold-off backs the block up so
    // its skid register fills and in_stall rises while bytes keep coming.
    initial
    begin : receiver
        int  phase_left;
        int  mode;
        int  tick;
        bit  held_long;
        phase_left = 0;
        mode       = 0;
        tick       = 0;
        held_long  = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held_long && bytes_sent >= 300)
            begin
                held_long = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                tick++;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= tick[1];
                    default: out_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // One byte beat. Bursts of random length with random gaps between them;
    // the odd long burst gives stretches with no sender idling at all.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        byte_value <= b;
        packet_end <= last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Builds a packet from header, CSRC list and payload, optionally cut to
    // cut_len bytes (0 keeps it whole), and sends it with packet_end on the
    // last byte.
    task automatic send_packet(input logic [7:0] oct0, input logic [7:0] oct1,
                               input logic [15:0] seq, input int pay_len,
                               input int cut_len);
        logic [7:0]  pkt[$];
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [31:0] csrc;
        int          len;
        ts   = $urandom();
        ssrc = $urandom();
        pkt  = {oct0, oct1, seq[15:8], seq[7:0],
                ts[31:24], ts[23:16], ts[15:8], ts[7:0],
                ssrc[31:24], ssrc[23:16], ssrc[15:8], ssrc[7:0]};
        for (int i = 0; i < oct0[3:0]; i++)
        begin
            csrc = $urandom();
            pkt.push_back(csrc[31:24]);
            pkt.push_back(csrc[23:16]);
            pkt.push_back(csrc[15:8]);
            pkt.push_back(csrc[7:0]);
        end
        for (int i = 0; i < pay_len; i++)
            pkt.push_back(8'($urandom()));
        len = (cut_len > 0 && cut_len < pkt.size()) ? cut_len : pkt.size();
        if (len < pkt.size())
            packets_cut++;
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], i == len - 1);
        packets_sent++;
    endtask

    // Sender holds off until the block has handed back everything owed.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin : stimulus
        logic [15:0] last_seq;
        logic [15:0] seq;
        logic [7:0]  oct0;
        logic [7:0]  oct1;
        logic [1:0]  ver;
        logic [3:0]  cc;
        int          pick;
        int          cut_len;
        int          pkt_idx;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        byte_value <= '0;
        packet_end <= 1'b0;
        bytes_sent   = 0;
        packets_sent = 0;
        packets_cut  = 0;
        burst_left   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte packet (short), an all-ones header with no CSRC
        // that ends on its last header byte (first packet), then an all-zero
        // header with one CSRC that ends on byte 12 (truncated, and sequence
        // wraps from 0xffff to 0 in order).
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 12; i++)
            send_byte((i == 0) ? 8'hF0 : 8'hFF, i == 11);
        for (int i = 0; i < 12; i++)
            send_byte((i == 0) ? 8'h01 : 8'h00, i == 11);
        last_seq = 16'h0000;

        // Random traffic: mostly well-formed packets with varied sequence
        // steps; the rest are cut in the header, on byte 12 or in the list.
        pkt_idx = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                seq = last_seq + 16'd1;
            else if (pick < 78)
            begin
                if ($urandom_range(0, 7) == 0)
                    seq = last_seq + 16'd32767;     // largest gap
                else
                    seq = last_seq + 16'($urandom_range(2, 40));
            end
            else if (pick < 88)
            begin
                if ($urandom_range(0, 7) == 0)
                    seq = last_seq + 16'd32768;     // smallest delta counted as backwards
                else
                    seq = last_seq + 16'($urandom_range(32768, 65535));
            end
            else if (pick < 95)
                seq = last_seq;
            else
                seq = 16'($urandom());

            ver  = ($urandom_range(0, 9) == 0) ? 2'($urandom()) : 2'b10;
            cc   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(4, 15))
                                               : 4'($urandom_range(0, 3));
            oct0 = {ver, 2'($urandom()), cc};
            oct1 = 8'($urandom());

            cut_len = 0;
            if ($urandom_range(0, 99) < 22)
            begin
                case ($urandom_range(0, 3))
                    0: cut_len = $urandom_range(1, 11);
                    1: cut_len = 12;
                    2: cut_len = (cc != 0) ? $urandom_range(13, 12 + 4 * cc) : 12;
                    default: cut_len = $urandom_range(1, 12 + 4 * cc);
                endcase
            end

            send_packet(oct0, oct1, seq, $urandom_range(0, 12), cut_len);
            // a header only counts toward the sequence history once byte 12 lands
            if (cut_len == 0 || cut_len >= 12)
                last_seq = seq;

            pkt_idx++;
            if (pkt_idx == 8 || pkt_idx == 22)
                drain();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d bytes in %0d packets (%0d cut short), %0d results checked",
                 bytes_sent, packets_sent + 3, packets_cut, compared);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/rhp_pkg.sv
design/rhp_core.sv
design/rtp_header_parser.sv
tb/sv/rtp_header_parser_checker.sv
tb/sv/rtp_header_parser_tb.sv
